// ===== design/lpht_pkg.sv =====
// Shared types and codes for the linear-probe hash table.
// Used by lpht_mem and linear_probe_hash_table; depends on nothing.
package lpht_pkg;

	// operation codes on func
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_ERASE  = 2'd2;

	// result status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;

	// slot state codes
	localparam logic [1:0] SLOT_EMPTY   = 2'd0;
	localparam logic [1:0] SLOT_VALID   = 2'd1;
	localparam logic [1:0] SLOT_DELETED = 2'd2;

	// one table entry as stored in memory
	typedef struct packed {
		logic [1:0]  st;
		logic [31:0] key;
		logic [31:0] val;
	} entry_t;

endpackage

// ===== design/lpht_home.sv =====
// Home-slot unit: key modulo slot count.
// A mask for a power-of-two slot count, otherwise a three-stage reciprocal multiply.
module lpht_home #(
	parameter int SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [31:0]                key,
	output logic                       done,
	output logic [$clog2(SLOTS)-1:0]   home
);

	localparam int IW = $clog2(SLOTS);

	generate
		if ((SLOTS & (SLOTS - 1)) == 0) begin : g_mask
			logic          done_q;
			logic [IW-1:0] home_q;

			// take the low key bits
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					home_q <= key[IW-1:0];
				end
			end

			assign done = done_q;
			assign home = home_q;
		end else begin : g_recip
			// quotient = key / SLOTS by multiply-high with a rounding fix-up,
			// remainder from the low bits of key - quotient * SLOTS
			localparam int              SH     = IW - 1;
			localparam logic [31:0]     MAGIC  = 32'((((64'd1 << 32) *
				((64'd1 << IW) - 64'(SLOTS))) / 64'(SLOTS)) + 64'd1);
			localparam logic [IW-1:0]   MOD_LO = IW'(SLOTS);

			logic          vld_s1;
			logic          vld_s2;
			logic          done_q;
			logic [31:0]   key_s1;
			logic [31:0]   mh_s1;
			logic [IW-1:0] q_s2;
			logic [IW-1:0] klo_s2;
			logic [IW-1:0] home_q;
			logic [31:0]   avg;
			logic [IW-1:0] quot;

			// fix up the multiply-high into the exact quotient
			always_comb begin
				avg  = mh_s1 + ((key_s1 - mh_s1) >> 1);
				quot = IW'(avg >> SH);
			end

			// advance the stage valids
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s1 <= 1'b0;
					vld_s2 <= 1'b0;
					done_q <= 1'b0;
				end else begin
					vld_s1 <= start;
					vld_s2 <= vld_s1;
					done_q <= vld_s2;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					key_s1 <= key;
					mh_s1  <= 32'((64'(key) * 64'(MAGIC)) >> 32);
				end
				if (vld_s1) begin
					q_s2   <= quot;
					klo_s2 <= key_s1[IW-1:0];
				end
				if (vld_s2) begin
					home_q <= klo_s2 - IW'(q_s2 * MOD_LO);
				end
			end

			assign done = done_q;
			assign home = home_q;
		end
	endgenerate

endmodule

// ===== design/lpht_mem.sv =====
// Slot memory: state, key and value per slot, one write and one read port.
// Read data is registered. Uses lpht_pkg::entry_t.
module lpht_mem #(
	parameter int SLOTS = 16
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [$clog2(SLOTS)-1:0]  waddr,
	input  lpht_pkg::entry_t          wdata,
	input  logic [$clog2(SLOTS)-1:0]  raddr,
	output lpht_pkg::entry_t          rdata
);

	lpht_pkg::entry_t mem [SLOTS];
	lpht_pkg::entry_t rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, every cycle
	always_ff @(posedge clk) begin
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

// ===== design/linear_probe_hash_table.sv =====
// Linear-probe hash table with SLOTS entries of 32-bit key and 32-bit value, held in one
// single-port-read memory. After reset the block sweeps the memory to mark every slot
// empty, and no word is accepted during the sweep. One word is worked on at a time:
// the home slot is computed (by a mask, or by a pipelined reciprocal multiply when SLOTS
// is not a power of two), then the probe reads one slot per cycle from the memory read
// port, then a write-back step writes the slot back and loads the result, so the probe
// length sets how long a word takes.
// A new word is accepted while the previous result still waits in the output register.
module linear_probe_hash_table #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] key,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] found_value,
	output logic [3:0]  slot_index,
	output logic [4:0]  valid_count,
	output logic        table_empty
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
	localparam logic [CW-1:0] NSLOTS    = CW'(SLOTS);
	localparam logic [CW-1:0] LAST_CNT  = CW'(SLOTS - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_PROBE = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]        state_q;
	logic [IW-1:0]     clr_q;
	logic [1:0]        func_q;
	logic [31:0]       key_q;
	logic [31:0]       value_q;
	logic [IW-1:0]     addr_q;
	logic [CW-1:0]     iss_cnt_q;
	logic [CW-1:0]     eval_cnt_q;
	logic              vld_s1;
	logic [IW-1:0]     eaddr_s1;
	logic              hit_q;
	logic [IW-1:0]     hit_addr_q;
	lpht_pkg::entry_t  hit_data_q;
	logic [CW-1:0]     cnt_q;

	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [31:0]       fval_q;
	logic [3:0]        slot_q;
	logic [4:0]        vcnt_q;
	logic              empty_q;

	logic              accept;
	logic              home_done;
	logic [IW-1:0]     home;
	lpht_pkg::entry_t  rdata;
	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	lpht_pkg::entry_t  mem_wdata;
	logic              hit;
	logic              finish;
	logic              changes;
	logic [CW-1:0]     cnt_nx;
	logic [IW+3:0]     slot_wide;
	logic [CW+4:0]     cnt_wide;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	lpht_home #(.SLOTS(SLOTS)) u_home (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (key),
		.done   (home_done),
		.home   (home)
	);

	lpht_mem #(.SLOTS(SLOTS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (addr_q),
		.rdata (rdata)
	);

	// match the slot that was read last cycle
	always_comb begin
		if (func_q == lpht_pkg::FUNC_INSERT) begin
			hit = (rdata.st != lpht_pkg::SLOT_VALID);
		end else if (func_q == lpht_pkg::FUNC_LOOKUP || func_q == lpht_pkg::FUNC_ERASE) begin
			hit = (rdata.st == lpht_pkg::SLOT_VALID) && (rdata.key == key_q);
		end else begin
			hit = 1'b0;
		end
	end

	// result leaves when the output register is free
	assign finish  = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign changes = hit_q && (func_q == lpht_pkg::FUNC_INSERT ||
		func_q == lpht_pkg::FUNC_ERASE);

	// new entry count
	always_comb begin
		cnt_nx = cnt_q;
		if (hit_q && func_q == lpht_pkg::FUNC_INSERT) begin
			cnt_nx = cnt_q + CW'(1);
		end else if (hit_q && func_q == lpht_pkg::FUNC_ERASE) begin
			cnt_nx = cnt_q - CW'(1);
		end
	end

	assign slot_wide = {4'b0, hit_addr_q};
	assign cnt_wide  = {5'b0, cnt_nx};

	// memory write: clearing sweep or write-back
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = hit_addr_q;
		mem_wdata = hit_data_q;
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '{st: lpht_pkg::SLOT_EMPTY, key: '0, val: '0};
		end else if (finish && changes) begin
			mem_we = 1'b1;
			if (func_q == lpht_pkg::FUNC_INSERT) begin
				mem_wdata = '{st: lpht_pkg::SLOT_VALID, key: key_q, val: value_q};
			end else begin
				mem_wdata.st = lpht_pkg::SLOT_DELETED;
			end
		end
	end

	// control state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			vld_s1     <= 1'b0;
			iss_cnt_q  <= '0;
			eval_cnt_q <= '0;
			hit_q      <= 1'b0;
			cnt_q      <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == LAST_SLOT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					vld_s1     <= 1'b0;
					iss_cnt_q  <= '0;
					eval_cnt_q <= '0;
					if (home_done) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					// issue next read
					vld_s1 <= (iss_cnt_q != NSLOTS);
					if (iss_cnt_q != NSLOTS) begin
						iss_cnt_q <= iss_cnt_q + CW'(1);
					end
					// evaluate previous read
					if (vld_s1) begin
						eval_cnt_q <= eval_cnt_q + CW'(1);
						if (hit) begin
							hit_q   <= 1'b1;
							state_q <= S_DONE;
						end else if (eval_cnt_q == LAST_CNT) begin
							hit_q   <= 1'b0;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (finish) begin
						cnt_q   <= cnt_nx;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// word and probe datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			key_q   <= key;
			value_q <= value;
		end
		if (state_q == S_HASH && home_done) begin
			addr_q <= home;
		end else if (state_q == S_PROBE && iss_cnt_q != NSLOTS) begin
			addr_q <= (addr_q == LAST_SLOT) ? '0 : addr_q + IW'(1);
		end
		if (state_q == S_PROBE) begin
			eaddr_s1 <= addr_q;
		end
		if (state_q == S_PROBE && vld_s1 && hit) begin
			hit_addr_q <= eaddr_s1;
			hit_data_q <= rdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			if (hit_q) begin
				status_q <= lpht_pkg::STATUS_OK;
				slot_q   <= slot_wide[3:0];
			end else begin
				status_q <= (func_q == lpht_pkg::FUNC_INSERT) ?
					lpht_pkg::STATUS_FULL : lpht_pkg::STATUS_NOTFOUND;
				slot_q   <= 4'd0;
			end
			fval_q  <= (hit_q && func_q == lpht_pkg::FUNC_LOOKUP) ? hit_data_q.val : 32'd0;
			vcnt_q  <= cnt_wide[4:0];
			empty_q <= (cnt_nx == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_value = fval_q;
	assign slot_index  = slot_q;
	assign valid_count = vcnt_q;
	assign table_empty = empty_q;

	// entry count stays within the table
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= NSLOTS)
		else $error("entry count exceeds slot count");

	// a probe never evaluates more than SLOTS slots
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE && vld_s1) |-> (eval_cnt_q < NSLOTS))
		else $error("probe ran past the table");

	// a failed operation reports slot and value zero
	a_miss_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != lpht_pkg::STATUS_OK) |->
		(slot_q == 4'd0 && fval_q == 32'd0))
		else $error("miss result carries slot or value");

	// erase never fires with an empty table
	a_erase_count: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && hit_q && func_q == lpht_pkg::FUNC_ERASE) |-> (cnt_q != '0))
		else $error("erase hit with zero entries");

	// no word is taken while the clearing sweep runs
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !accept)
		else $error("word accepted during clearing sweep");

endmodule
